FILE: src/change_coalescing_packetizer_top_defines.svh
// Assertion macros for the change coalescing packetizer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CHANGE_COALESCING_PACKETIZER_TOP_DEFINES_SVH
`define CHANGE_COALESCING_PACKETIZER_TOP_DEFINES_SVH

// The condition implies the consequence in the same cycle.
`define CCP_ASSERT_IMPL(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// The condition implies the consequence in the next cycle.
`define CCP_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types, constants and helper functions of the change coalescing
// packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccp_pkg;

	// Default parameter values.
	localparam int REC_DEFAULT  = 1024;
	localparam int SEQB_DEFAULT = 48;

	// Packet layout.
	localparam int HEADER_BYTES = 16;
	localparam int ID_BYTES     = 8;
	localparam int MTU_MIN      = 32;
	localparam int MTU_MAX      = 9000;

	// Result queue.
	localparam int OQ_DEPTH = 8;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	// Register port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register reset values.
	localparam logic [31:0] RST_BASE_ID   = 32'd0;
	localparam logic [3:0]  RST_VALUE_B   = 4'd8;
	localparam logic [13:0] RST_MTU       = 14'd1472;
	localparam logic [31:0] RST_HEARTBEAT = 32'd1000000;
	localparam logic [31:0] RST_MAX_AGE   = 32'd1000;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_SENT  = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_OVF   = 2'd2,
		KIND_RANGE = 2'd3
	} kind_t;

	// Register indexes.
	typedef enum logic [2:0] {
		REG_BASE_ID   = 3'd0,
		REG_VALUE_B   = 3'd1,
		REG_MTU       = 3'd2,
		REG_HEARTBEAT = 3'd3,
		REG_MAX_AGE   = 3'd4
	} reg_idx_t;

	// One input transaction.
	typedef struct packed {
		logic        op;
		logic [31:0] record_id;
		logic [31:0] revision;
		logic [63:0] value;
		logic [62:0] now_usec;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [47:0] packet_seq;
		logic [13:0]        length_bytes;
		logic [62:0]        send_time;
		logic [13:0]        entry_offset;
		logic [31:0]        out_record_id;
		logic [63:0]        out_value;
		logic               last;
	} result_t;

	// Effective configuration seen by the datapath.
	typedef struct packed {
		logic [31:0] base_id;
		logic [4:0]  entry_bytes;
		logic [63:0] value_mask;
		logic [13:0] mtu;
		logic [31:0] heartbeat;
		logic [31:0] max_age;
	} cfg_t;

	// Result queue status.
	typedef struct packed {
		logic                room;
		logic [OQ_CNT_W-1:0] count;
	} oq_status_t;

	// Value bytes clamped to 1..8.
	function automatic logic [3:0] eff_value_bytes(logic [3:0] vb);
		logic [3:0] r;
		if (vb == 4'd0) begin
			r = 4'd1;
		end else if (vb > 4'd8) begin
			r = 4'd8;
		end else begin
			r = vb;
		end
		return r;
	endfunction

	// Mask keeping the low value bytes of a value.
	function automatic logic [63:0] value_mask(logic [3:0] vb);
		logic [63:0] m;
		case (vb)
			4'd0, 4'd1: m = 64'h0000_0000_0000_00FF;
			4'd2:       m = 64'h0000_0000_0000_FFFF;
			4'd3:       m = 64'h0000_0000_00FF_FFFF;
			4'd4:       m = 64'h0000_0000_FFFF_FFFF;
			4'd5:       m = 64'h0000_00FF_FFFF_FFFF;
			4'd6:       m = 64'h0000_FFFF_FFFF_FFFF;
			4'd7:       m = 64'h00FF_FFFF_FFFF_FFFF;
			default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	// Payload capacity clamped to the legal range.
	function automatic logic [13:0] eff_mtu(logic [13:0] mtu);
		logic [13:0] r;
		if (mtu < 14'(MTU_MIN)) begin
			r = 14'(MTU_MIN);
		end else if (mtu > 14'(MTU_MAX)) begin
			r = 14'(MTU_MAX);
		end else begin
			r = mtu;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/ccp_regs.sv
// ----------------------------------------------------------------------------
// ccp_regs
// Configuration registers behind the APB-style port, with the derived
// effective settings for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_regs import ccp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [31:0] base_id_q;
	logic [3:0]  value_b_q;
	logic [13:0] mtu_q;
	logic [31:0] heartbeat_q;
	logic [31:0] max_age_q;
	logic        wr_fire;
	reg_idx_t    reg_idx;
	logic [3:0]  vb_eff;

	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q   <= RST_BASE_ID;
			value_b_q   <= RST_VALUE_B;
			mtu_q       <= RST_MTU;
			heartbeat_q <= RST_HEARTBEAT;
			max_age_q   <= RST_MAX_AGE;
		end else if (wr_fire) begin
			case (reg_idx)
				REG_BASE_ID:   base_id_q   <= pwdata;
				REG_VALUE_B:   value_b_q   <= pwdata[3:0];
				REG_MTU:       mtu_q       <= pwdata[13:0];
				REG_HEARTBEAT: heartbeat_q <= pwdata;
				REG_MAX_AGE:   max_age_q   <= pwdata;
				default: ;
			endcase
		end
	end

	// Register reads return the written value.
	always_comb begin
		case (reg_idx)
			REG_BASE_ID:   prdata = base_id_q;
			REG_VALUE_B:   prdata = {28'd0, value_b_q};
			REG_MTU:       prdata = {18'd0, mtu_q};
			REG_HEARTBEAT: prdata = heartbeat_q;
			REG_MAX_AGE:   prdata = max_age_q;
			default:       prdata = '0;
		endcase
	end

	// Effective settings with out-of-range values clamped.
	assign vb_eff          = eff_value_bytes(value_b_q);
	assign cfg.base_id     = base_id_q;
	assign cfg.entry_bytes = 5'(ID_BYTES) + {1'b0, vb_eff};
	assign cfg.value_mask  = value_mask(vb_eff);
	assign cfg.mtu         = eff_mtu(mtu_q);
	assign cfg.heartbeat   = heartbeat_q;
	assign cfg.max_age     = max_age_q;

endmodule

`default_nettype wire

FILE: src/ccp_rev_table.sv
// ----------------------------------------------------------------------------
// ccp_rev_table
// Last-sent revision memory: one read and one write port, registered read
// data, forwarding of the latest write, and a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_rev_table import ccp_pkg::*; #(
	parameter  int RECORDS = REC_DEFAULT,
	localparam int IDX_W   = (RECORDS > 1) ? $clog2(RECORDS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	output logic      [31:0]      rd_rev,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire logic [31:0]      wr_rev,
	output logic                  clearing
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORDS - 1);

	logic [31:0]      mem [RECORDS];
	logic [31:0]      rd_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             clr_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [31:0]      fwd_rev_q;
	logic             m_wr;
	logic [IDX_W-1:0] m_addr;
	logic [31:0]      m_data;

	assign clearing = clr_q;

	// The clearing pass owns the write port until it is done.
	assign m_wr   = clr_q || wr_en;
	assign m_addr = clr_q ? clr_cnt_q : wr_idx;
	assign m_data = clr_q ? 32'hFFFF_FFFF : wr_rev;

	// Memory array with registered read.
	always_ff @(posedge clk) begin
		if (m_wr) begin
			mem[m_addr] <= m_data;
		end
		rd_q     <= mem[rd_idx];
		rd_idx_q <= rd_idx;
	end

	// Clearing pass, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == LAST_IDX) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
		end
	end

	// Latest write, covering a read taken at the same edge as the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_idx_q <= wr_idx;
			fwd_rev_q <= wr_rev;
		end
	end

	assign rd_rev = (fwd_valid_q && (fwd_idx_q == rd_idx_q)) ? fwd_rev_q : rd_q;

endmodule

`default_nettype wire

FILE: src/ccp_packer.sv
// ----------------------------------------------------------------------------
// ccp_packer
// Packet state and result generation: change detection, entry placement,
// packet sends on overflow, age and heartbeat, sequence numbering.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_packer import ccp_pkg::*; #(
	parameter  int RECORDS  = REC_DEFAULT,
	parameter  int SEQ_BITS = SEQB_DEFAULT,
	localparam int IDX_W    = (RECORDS > 1) ? $clog2(RECORDS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             valid_s1,
	input  wire item_t            item_s1,
	input  wire logic [IDX_W-1:0] idx_s1,
	input  wire logic             in_range_s1,
	input  wire logic [31:0]      rd_rev,
	output logic                  wr_en,
	output logic      [IDX_W-1:0] wr_idx,
	output logic      [31:0]      wr_rev,
	output logic      [1:0]       push_n,
	output result_t               res0,
	output result_t               res1,
	output logic                  ovf_err
);

	localparam logic [SEQ_BITS-1:0] SEQ_MAXV = {1'b0, {(SEQ_BITS - 1){1'b1}}};
	localparam logic [SEQ_BITS-1:0] SEQ_ONE  = SEQ_BITS'(1);

	logic [SEQ_BITS-1:0] next_q;
	logic [SEQ_BITS-1:0] open_q;
	logic [13:0]         used_q;
	logic                pend_q;
	logic [62:0]         first_t_q;
	logic [62:0]         last_t_q;
	logic                ovf_q;

	logic                chg;
	logic                tick;
	logic                need_send;
	logic                age_hit;
	logic                hb_hit;
	logic                hb_fresh;
	logic                send_do;
	logic [SEQ_BITS-1:0] send_seq;
	logic [13:0]         send_len;
	logic [SEQ_BITS-1:0] inc;
	logic                pos;
	logic                wrap;
	logic [SEQ_BITS-1:0] next_after;
	logic                place;
	logic [13:0]         used_base;
	logic                new_pkt;
	logic [SEQ_BITS-1:0] open_new;
	logic [13:0]         off;
	logic [13:0]         used_new;
	logic [14:0]         fill_sum;
	logic [62:0]         now;

	// Sign-extend a sequence and keep the 48 header bits.
	function automatic logic [47:0] seq_out(logic [SEQ_BITS-1:0] s);
		logic signed [SEQ_BITS-1:0] ss;
		logic signed [63:0]         w;
		ss = s;
		w  = ss;
		return w[47:0];
	endfunction

	// True when now is not before since and at least lim has passed.
	function automatic logic reached(logic [62:0] t, logic [62:0] since, logic [31:0] lim);
		logic [63:0] d;
		d = {1'b0, t} - {1'b0, since};
		return !d[63] && (d[62:0] >= {31'd0, lim});
	endfunction

	assign now     = item_s1.now_usec;
	assign ovf_err = ovf_q;

	// Decide what this transaction does.
	always_comb begin
		chg       = valid_s1 && !ovf_q && !item_s1.op && in_range_s1 &&
			(item_s1.revision != rd_rev);
		tick      = valid_s1 && !ovf_q && item_s1.op;
		fill_sum  = {1'b0, used_q} + 15'(cfg.entry_bytes);
		need_send = fill_sum > {1'b0, cfg.mtu};
		age_hit   = pend_q && reached(now, first_t_q, cfg.max_age);
		hb_hit    = reached(now, last_t_q, cfg.heartbeat);
		send_do   = (chg && need_send) || (tick && (age_hit || hb_hit));
		hb_fresh  = tick && !age_hit && (used_q == 14'd0);
		send_seq  = hb_fresh ? (SEQ_BITS'(0) - next_q) : open_q;
		send_len  = hb_fresh ? 14'(HEADER_BYTES) : used_q;

		// Sequence advance for a numbered packet.
		inc        = next_q + SEQ_ONE;
		pos        = !send_seq[SEQ_BITS-1];
		wrap       = send_do && pos && (inc == SEQ_MAXV);
		next_after = (send_do && pos) ? inc : next_q;

		// Entry placement into the open or a fresh packet.
		place     = chg && !wrap;
		used_base = send_do ? 14'd0 : used_q;
		new_pkt   = (used_base == 14'd0);
		open_new  = new_pkt ? next_after : open_q;
		off       = new_pkt ? 14'(HEADER_BYTES) : used_base;
		used_new  = off + 14'(cfg.entry_bytes);
	end

	// Table update for a placed entry.
	assign wr_en  = place;
	assign wr_idx = idx_s1;
	assign wr_rev = item_s1.revision;

	// Result assembly.
	always_comb begin
		result_t r_sent;
		result_t r_entry;
		result_t r_code;

		r_sent              = '0;
		r_sent.kind         = KIND_SENT;
		r_sent.packet_seq   = seq_out(send_seq);
		r_sent.length_bytes = send_len;
		r_sent.send_time    = now;

		r_entry               = '0;
		r_entry.kind          = KIND_ENTRY;
		r_entry.packet_seq    = seq_out(open_new);
		r_entry.entry_offset  = off;
		r_entry.out_record_id = item_s1.record_id;
		r_entry.out_value     = item_s1.value & cfg.value_mask;

		r_code      = '0;
		r_code.kind = KIND_OVF;

		res0   = '0;
		res1   = '0;
		push_n = 2'd0;
		if (valid_s1 && ovf_q) begin
			res0   = r_code;
			push_n = 2'd1;
		end else if (valid_s1 && !item_s1.op && !in_range_s1) begin
			res0      = r_code;
			res0.kind = KIND_RANGE;
			push_n    = 2'd1;
		end else if (send_do) begin
			res0 = r_sent;
			if (wrap) begin
				res1   = r_code;
				push_n = 2'd2;
			end else if (place) begin
				res1   = r_entry;
				push_n = 2'd2;
			end else begin
				push_n = 2'd1;
			end
		end else if (place) begin
			res0   = r_entry;
			push_n = 2'd1;
		end
		res0.last = (push_n == 2'd1);
		res1.last = 1'b1;
	end

	// Packet state. A placed entry takes precedence over the send that made
	// room for it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q    <= SEQ_ONE;
			open_q    <= '0;
			used_q    <= '0;
			pend_q    <= 1'b0;
			first_t_q <= '0;
			last_t_q  <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (send_do) begin
				last_t_q <= now;
				next_q   <= next_after;
			end
			if (place) begin
				open_q    <= open_new;
				used_q    <= used_new;
				pend_q    <= 1'b1;
				first_t_q <= now;
			end else if (send_do) begin
				open_q <= send_seq;
				if (wrap) begin
					ovf_q  <= 1'b1;
					used_q <= send_len;
				end else begin
					used_q <= 14'd0;
					pend_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/ccp_out_queue.sv
// ----------------------------------------------------------------------------
// ccp_out_queue
// Result queue: takes up to two results per cycle, delivers one per cycle
// while result_stall is low, on the valid/stall channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_out_queue import ccp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  wire result_t    res0,
	input  wire result_t    res1,
	output result_t         result,
	output logic            result_valid,
	input  wire logic       result_stall,
	output oq_status_t      status
);

	result_t             mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic [OQ_PTR_W-1:0] wr_nxt;
	logic                pop;

	assign wr_nxt       = wr_ptr_q + OQ_PTR_W'(1);
	assign result_valid = (count_q != '0);
	assign result       = mem[rd_ptr_q];
	assign pop          = result_valid && !result_stall;

	// Room for two transactions in flight, each adding up to two results.
	assign status.count = count_q;
	assign status.room  = (count_q <= OQ_CNT_W'(OQ_DEPTH - 4));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem[wr_nxt] <= res1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: src/change_coalescing_packetizer_top.sv
// ----------------------------------------------------------------------------
// change_coalescing_packetizer_top
// Record-change coalescing packetizer: drops unchanged records, places
// changed ones into the open packet and reports packet sends.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions (item_valid/item_stall) carry a record change or a time
// tick. Result transactions (result_valid/result_stall) carry packet sends,
// placed entries and error codes; each input yields zero, one or two results,
// the final one marked by last. Registers are to be written through the APB-style
// port only while the block is idle; the block itself does not enforce this.
// One input transaction is accepted per cycle while item_stall is low; it is
// registered into stage 1 with the memory read data, and its results go into
// the result queue. The rate is set by the revision memory: one read at
// acceptance, one write from stage 1, the newest write forwarded to the
// following read. Inputs that make two results deliver them one at a time;
// input is held off while the result queue holds more than four results.
// After reset the revision memory is cleared to all ones, one entry per cycle;
// input is held off during that pass, register writes are taken as usual.
// When the receiver stalls, the results wait in an eight-entry queue and the
// input is held off once that queue nears full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "change_coalescing_packetizer_top_defines.svh"

module change_coalescing_packetizer_top import ccp_pkg::*; #(
	parameter int RECORDS  = REC_DEFAULT,
	parameter int SEQ_BITS = SEQB_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire item_t             item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output result_t                result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam int IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam logic [OQ_CNT_W-1:0] S1_ROOM = OQ_CNT_W'(OQ_DEPTH - 2);

	cfg_t             cfg;
	oq_status_t       oq_stat;
	logic             clearing;
	logic             accept;
	logic [31:0]      rel_id;
	logic             in_range;
	logic [IDX_W-1:0] rd_idx;
	logic [31:0]      rd_rev;
	logic             valid_s1;
	item_t            item_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             in_range_s1;
	logic             tbl_wr_en;
	logic [IDX_W-1:0] tbl_wr_idx;
	logic [31:0]      tbl_wr_rev;
	logic [1:0]       push_n;
	result_t          res0;
	result_t          res1;
	logic             ovf_err;

	// Configuration registers.
	ccp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Acceptance and table index of the incoming transaction.
	assign item_stall = clearing || !oq_stat.room;
	assign accept     = item_valid && !item_stall;
	assign rel_id     = item.record_id - cfg.base_id;
	assign in_range   = rel_id < 32'(RECORDS);
	assign rd_idx     = rel_id[IDX_W-1:0];

	// Stage 1 registers, aligned with the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			idx_s1      <= rd_idx;
			in_range_s1 <= in_range;
		end
	end

	// Last-sent revision memory.
	ccp_rev_table #(
		.RECORDS (RECORDS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_rev   (rd_rev),
		.wr_en    (tbl_wr_en),
		.wr_idx   (tbl_wr_idx),
		.wr_rev   (tbl_wr_rev),
		.clearing (clearing)
	);

	// Packet state and result generation.
	ccp_packer #(
		.RECORDS  (RECORDS),
		.SEQ_BITS (SEQ_BITS)
	) u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.idx_s1      (idx_s1),
		.in_range_s1 (in_range_s1),
		.rd_rev      (rd_rev),
		.wr_en       (tbl_wr_en),
		.wr_idx      (tbl_wr_idx),
		.wr_rev      (tbl_wr_rev),
		.push_n      (push_n),
		.res0        (res0),
		.res1        (res1),
		.ovf_err     (ovf_err)
	);

	// Result queue.
	ccp_out_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_n       (push_n),
		.res0         (res0),
		.res1         (res1),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (oq_stat)
	);

	// A transaction in stage 1 always finds room for its results.
	`CCP_ASSERT_IMPL(a_queue_room, valid_s1, oq_stat.count <= S1_ROOM, "result queue overrun")
	// The sequence overflow error is sticky until reset.
	`CCP_ASSERT_NEXT(a_ovf_sticky, ovf_err, ovf_err, "overflow error cleared")
	// No entry update competes with the clearing pass.
	`CCP_ASSERT_IMPL(a_no_write_clear, clearing, !tbl_wr_en, "table write during clearing")

endmodule

`default_nettype wire
